@@ sv/bae_pkg.sv @@
// ----------------------------------------------------------------------------
// bae_pkg
// Shared constants, types and helper functions of the binary arithmetic
// encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

    localparam int MAX_PRECISION   = 32;
    localparam int COUNT_BITS      = 16;
    localparam int RESET_PRECISION = 12;

    localparam int FIELD_W  = 16;
    localparam int PREC_W   = 6;
    localparam int PREC_CAP = (MAX_PRECISION < 32) ? MAX_PRECISION : 32;
    localparam int BOUND_W  = PREC_CAP;
    localparam int RANGE_W  = BOUND_W + 1;
    localparam int IDX_W    = $clog2(BOUND_W);
    localparam int CU_W     = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;
    localparam int PROD_W   = RANGE_W + CU_W;
    localparam int DIV_STEPS = (PROD_W + 1) / 2;
    localparam int DIV_W    = 2 * DIV_STEPS;
    localparam int CNT_MAX  = (DIV_STEPS > BOUND_W) ? DIV_STEPS : BOUND_W;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic apply;
        logic shift_emit;
        logic flush_emit;
        logic single_emit;
    } bae_cmd_t;

    typedef struct packed {
        logic req_flush;
        logic req_zero;
        logic div_last;
        logic empty_sel;
        logic top_match;
        logic shift_last;
        logic flush_last;
        logic slot_free;
    } bae_status_t;

    function automatic logic [PREC_W-1:0] eff_prec(input logic [PREC_W-1:0] v);
        logic [PREC_W-1:0] p;
        p = v;
        if (v > PREC_W'(PREC_CAP))
        begin
            p = PREC_W'(PREC_CAP);
        end
        else if (v < PREC_W'(2))
        begin
            p = PREC_W'(2);
        end
        return p;
    endfunction

    function automatic logic [BOUND_W-1:0] valid_mask(input logic [PREC_W-1:0] p);
        return {BOUND_W{1'b1}} >> (PREC_W'(BOUND_W) - p);
    endfunction

endpackage

@@ sv/bae_if.sv @@
// ----------------------------------------------------------------------------
// bae_if
// Valid/ready channels of the binary arithmetic encoder: request items in,
// result items out.
// ----------------------------------------------------------------------------
interface bae_item_if import bae_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic               symbol;
    logic               mps_value;
    logic [FIELD_W-1:0] count_mps;
    logic [FIELD_W-1:0] total_count;

    modport source (output valid, action, symbol, mps_value, count_mps, total_count,
                    input ready);
    modport sink (input valid, action, symbol, mps_value, count_mps, total_count,
                  output ready);
endinterface

interface bae_result_if ();
    logic valid;
    logic ready;
    logic out_bit;
    logic has_bit;
    logic last;
    logic empty_interval;

    modport source (output valid, out_bit, has_bit, last, empty_interval, input ready);
    modport sink (input valid, out_bit, has_bit, last, empty_interval, output ready);
endinterface

@@ sv/bae_ctrl.sv @@
// ----------------------------------------------------------------------------
// bae_ctrl
// Controller of the encoder: sequences multiply, division, interval update
// and bit emission for one item at a time.
// ----------------------------------------------------------------------------
module bae_ctrl import bae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bae_status_t st,
    output bae_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_APPLY  = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_SINGLE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.req_flush)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (st.req_zero)
                    begin
                        state_next = S_SINGLE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = st.empty_sel ? S_SINGLE : S_SHIFT;
            end
            S_SHIFT:
            begin
                if (!st.top_match)
                begin
                    state_next = S_SINGLE;
                end
                else if (st.slot_free)
                begin
                    cmd.shift_emit = 1'b1;
                    if (st.shift_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (st.slot_free)
                begin
                    cmd.flush_emit = 1'b1;
                    if (st.flush_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SINGLE:
            begin
                if (st.slot_free)
                begin
                    cmd.single_emit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_emit || cmd.flush_emit || cmd.single_emit) |-> st.slot_free)
        else $error("result emitted into an occupied output register");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !in_ready)
        else $error("second item taken while one is in work");

endmodule

@@ sv/bae_dp.sv @@
// ----------------------------------------------------------------------------
// bae_dp
// Datapath of the encoder: interval bounds, range multiplier, radix-4
// restoring divider, bit shifter and output register.
// ----------------------------------------------------------------------------
module bae_dp import bae_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [PREC_W-1:0]  cfg_data,
    input  logic               in_action,
    input  logic               in_symbol,
    input  logic               in_mps_value,
    input  logic [FIELD_W-1:0] in_count_mps,
    input  logic [FIELD_W-1:0] in_total_count,
    input  bae_cmd_t           cmd,
    output bae_status_t        st,
    bae_result_if.source       out_ch
);

    logic [PREC_W-1:0]  prec_reg;
    logic [BOUND_W-1:0] low_reg;
    logic [BOUND_W-1:0] high_reg;
    logic               is_mps_reg;
    logic [CU_W-1:0]    c_reg;
    logic [CU_W-1:0]    t_reg;
    logic [RANGE_W-1:0] range_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [CU_W-1:0]    rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               empty_reg;

    logic               out_valid_reg;
    logic               out_bit_reg;
    logic               has_bit_reg;
    logic               last_reg;
    logic               empty_out_reg;

    logic [PREC_W-1:0]  p;
    logic [BOUND_W-1:0] mask;
    logic [IDX_W-1:0]   idx_top;
    logic [IDX_W-1:0]   idx_nxt;
    logic [IDX_W-1:0]   idx_fl;
    logic               cnt_final;
    logic [CU_W-1:0]    c_in;
    logic [CU_W-1:0]    t_in;
    logic [PROD_W-1:0]  prod;
    logic [CU_W:0]      r1;
    logic [CU_W:0]      r2;
    logic [CU_W:0]      r1s;
    logic [CU_W:0]      r2s;
    logic               ge1;
    logic               ge2;
    logic [DIV_W-1:0]   q1;
    logic [DIV_W-1:0]   q2;
    logic [RANGE_W-1:0] split;
    logic [RANGE_W-1:0] lps_low;
    logic [RANGE_W-1:0] mps_high;
    logic               emit;

    assign p         = eff_prec(prec_reg);
    assign mask      = valid_mask(p);
    assign idx_top   = IDX_W'(p - PREC_W'(1));
    assign idx_nxt   = IDX_W'(p - PREC_W'(2));
    assign idx_fl    = IDX_W'(p - PREC_W'(1) - PREC_W'(cnt_reg));
    assign cnt_final = (cnt_reg == CNT_W'(p - PREC_W'(1)));

    assign c_in = in_count_mps[CU_W-1:0];
    assign t_in = in_total_count[CU_W-1:0];

    assign prod = PROD_W'(range_reg) * PROD_W'(c_reg);

    // two restoring division steps per cycle
    assign r1  = {rem_reg, div_reg[DIV_W-1]};
    assign ge1 = (r1 >= {1'b0, t_reg});
    assign r1s = ge1 ? (r1 - {1'b0, t_reg}) : r1;
    assign q1  = {div_reg[DIV_W-2:0], ge1};
    assign r2  = {r1s[CU_W-1:0], q1[DIV_W-1]};
    assign ge2 = (r2 >= {1'b0, t_reg});
    assign r2s = ge2 ? (r2 - {1'b0, t_reg}) : r2;
    assign q2  = {q1[DIV_W-2:0], ge2};

    assign split    = div_reg[RANGE_W-1:0];
    assign lps_low  = {1'b0, low_reg} + split;
    assign mps_high = {1'b0, low_reg} + split - RANGE_W'(1);

    assign emit = cmd.shift_emit || cmd.flush_emit || cmd.single_emit;

    always_comb
    begin
        st            = '0;
        st.req_flush  = in_action;
        st.req_zero   = (t_in == '0);
        st.div_last   = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        st.empty_sel  = is_mps_reg ? (split == '0) : (split >= range_reg);
        st.top_match  = (low_reg[idx_top] == high_reg[idx_top]);
        st.shift_last = cnt_final || (low_reg[idx_nxt] != high_reg[idx_nxt]);
        st.flush_last = cnt_final;
        st.slot_free  = !out_valid_reg || out_ch.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prec_reg <= PREC_W'(RESET_PRECISION);
            low_reg  <= '0;
            high_reg <= valid_mask(eff_prec(PREC_W'(RESET_PRECISION)));
        end
        else if (cfg_we)
        begin
            prec_reg <= cfg_data;
            low_reg  <= '0;
            high_reg <= valid_mask(eff_prec(cfg_data));
        end
        else if (cmd.apply && !st.empty_sel)
        begin
            if (is_mps_reg)
            begin
                high_reg <= BOUND_W'(mps_high);
            end
            else
            begin
                low_reg <= BOUND_W'(lps_low);
            end
        end
        else if (cmd.shift_emit)
        begin
            low_reg  <= (low_reg << 1) & mask;
            high_reg <= ((high_reg << 1) & mask) | BOUND_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            is_mps_reg <= (in_symbol == in_mps_value);
            c_reg      <= (c_in > t_in) ? t_in : c_in;
            t_reg      <= t_in;
            range_reg  <= {1'b0, high_reg} - {1'b0, low_reg} + RANGE_W'(1);
            empty_reg  <= (t_in == '0);
        end
        else if (cmd.mul)
        begin
            div_reg <= DIV_W'(prod);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= q2;
            rem_reg <= r2s[CU_W-1:0];
        end
        else if (cmd.apply)
        begin
            empty_reg <= st.empty_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.accept || cmd.mul || cmd.apply)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step || cmd.shift_emit || cmd.flush_emit)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_emit)
        begin
            out_bit_reg   <= low_reg[idx_top];
            has_bit_reg   <= 1'b1;
            last_reg      <= st.shift_last;
            empty_out_reg <= 1'b0;
        end
        else if (cmd.flush_emit)
        begin
            out_bit_reg   <= low_reg[idx_fl];
            has_bit_reg   <= 1'b1;
            last_reg      <= cnt_final;
            empty_out_reg <= 1'b0;
        end
        else if (cmd.single_emit)
        begin
            out_bit_reg   <= 1'b0;
            has_bit_reg   <= 1'b0;
            last_reg      <= 1'b1;
            empty_out_reg <= empty_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_bit        = out_bit_reg;
    assign out_ch.has_bit        = has_bit_reg;
    assign out_ch.last           = last_reg;
    assign out_ch.empty_interval = empty_out_reg;

    a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (split <= range_reg))
        else $error("interval split beyond range");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && !st.empty_sel) |=> (low_reg <= high_reg))
        else $error("low bound above high bound after update");

    a_flush_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush_emit && !cfg_we) |=> $stable(low_reg))
        else $error("flush changed the low bound");

endmodule

@@ sv/binary_arithmetic_encoder.sv @@
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// Integer binary arithmetic encoder with a configurable interval width.
//
// in_ch takes one item at a time: action 0 encodes symbol against the
// count_mps / total_count model, action 1 flushes the low bound.
// out_ch gives one item per emitted bit, last marks the final one of an
// input item; an encode that emits nothing or hits an empty subinterval
// gives one item with has_bit low.
// Encode: the range is taken at acceptance, then come multiply, the
// two-bit-per-cycle divider and the interval update, then one result per
// cycle while the receiver takes them; a zero total skips these steps and
// gives its item directly. The next item is taken once the last result
// is in the output register. Flush: P results, one per cycle after acceptance while the receiver takes them.
// cfg_we/cfg_data write the precision and restart the interval.
// Reset sets precision 12, low 0, high 4095 and empties the output register.
// A stalled receiver holds the output register; the encoder waits with it.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder import bae_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [PREC_W-1:0] cfg_data,
    bae_item_if.sink          in_ch,
    bae_result_if.source      out_ch
);

    bae_cmd_t    cmd;
    bae_status_t st;
    logic        in_ready;

    bae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bae_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_action      (in_ch.action),
        .in_symbol      (in_ch.symbol),
        .in_mps_value   (in_ch.mps_value),
        .in_count_mps   (in_ch.count_mps),
        .in_total_count (in_ch.total_count),
        .cmd            (cmd),
        .st             (st),
        .out_ch         (out_ch)
    );

    assign in_ch.ready = in_ready;

endmodule

@@ tb/binary_arithmetic_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_tb
// Self-checking bench for the binary arithmetic encoder. Encode and close
// items go in over the request channel in bursts with random gaps. An
// in-bench model of the interval bounds predicts every emitted bit item. A
// stalling receiver checks each result item against the oldest prediction.
// Directed cases cover the count and precision extremes and the empty
// subinterval. Random phases at several precisions follow.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_tb import bae_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_CLOSE  = 1'b1;
    localparam int   MAX_STALL  = 20;
    localparam int   MAX_GAP    = 40;
    localparam int   TAIL_WAIT  = 40;

    typedef struct packed {
        logic               action;
        logic               symbol;
        logic               mps_value;
        logic [FIELD_W-1:0] count_mps;
        logic [FIELD_W-1:0] total_count;
    } code_req_t;

    typedef struct packed {
        logic out_bit;
        logic has_bit;
        logic last;
        logic empty_interval;
    } bit_item_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [PREC_W-1:0] cfg_data;

    bae_item_if   in_ch ();
    bae_result_if out_ch ();

    binary_arithmetic_encoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    bit_item_t         pending_bits[$];
    logic [PREC_W-1:0] prec_reg;
    logic [63:0]       low_q;
    logic [63:0]       high_q;

    int errors      = 0;
    int burst_left  = 0;
    int n_items     = 0;
    int n_closes    = 0;
    int n_checked   = 0;
    int n_empty     = 0;
    int n_prec_sets = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int clamp_prec(input logic [PREC_W-1:0] v);
        int p;
        p = int'(v);
        if (p > PREC_CAP)
        begin
            p = PREC_CAP;
        end
        if (p < 2)
        begin
            p = 2;
        end
        return p;
    endfunction

    function automatic void restart_interval();
        low_q  = 64'd0;
        high_q = (64'd1 << clamp_prec(prec_reg)) - 64'd1;
    endfunction

    function automatic void predict_bits(input code_req_t r);
        int          p;
        int          n;
        logic [63:0] mask;
        logic [63:0] top;
        logic [63:0] l0;
        logic [63:0] u0;
        logic [63:0] c;
        logic [63:0] t;
        logic [63:0] range_w;
        logic [63:0] split;
        logic [63:0] l1;
        logic [63:0] u1;
        logic        is_mps;
        bit_item_t   res[$];
        bit_item_t   b;

        p    = clamp_prec(prec_reg);
        mask = (64'd1 << p) - 64'd1;
        top  = 64'd1 << (p - 1);
        l0   = low_q & mask;
        u0   = high_q & mask;
        n    = 0;
        if (r.action == ACT_CLOSE)
        begin
            l1 = l0;
            for (int i = 0; i < p; i++)
            begin
                b = '{out_bit: (l1 & top) != 0, has_bit: 1'b1, last: (i == p - 1),
                      empty_interval: 1'b0};
                res.push_back(b);
                l1 = (l1 << 1) & mask;
            end
        end
        else
        begin
            is_mps  = (r.symbol == r.mps_value);
            c       = 64'(r.count_mps);
            t       = 64'(r.total_count);
            range_w = u0 - l0 + 64'd1;
            if (t == 0)
            begin
                split = 64'd0;
            end
            else
            begin
                if (c > t)
                begin
                    c = t;
                end
                split = (range_w / t) * c + ((range_w % t) * c) / t;
            end
            if (t == 0 || (is_mps && split == 0) || (!is_mps && split >= range_w))
            begin
                b = '{out_bit: 1'b0, has_bit: 1'b0, last: 1'b1, empty_interval: 1'b1};
                res.push_back(b);
            end
            else
            begin
                if (is_mps)
                begin
                    l1 = l0;
                    u1 = l0 + split - 64'd1;
                end
                else
                begin
                    l1 = l0 + split;
                    u1 = u0;
                end
                while (n < p && ((l1 & top) != 0) == ((u1 & top) != 0))
                begin
                    b = '{out_bit: (l1 & top) != 0, has_bit: 1'b1, last: 1'b0,
                          empty_interval: 1'b0};
                    res.push_back(b);
                    n++;
                    l1 = (l1 << 1) & mask;
                    u1 = ((u1 << 1) & mask) | 64'd1;
                end
                low_q  = l1;
                high_q = u1;
                if (n == 0)
                begin
                    b = '{out_bit: 1'b0, has_bit: 1'b0, last: 1'b1, empty_interval: 1'b0};
                    res.push_back(b);
                end
                else
                begin
                    res[n-1].last = 1'b1;
                end
            end
        end
        foreach (res[i])
        begin
            pending_bits.push_back(res[i]);
        end
    endfunction

    // receiver: stall mode is picked anew at the end of each random-length segment
    initial
    begin
        int        mode;
        int        seg_left;
        int        stall_cnt;
        bit_item_t got;
        bit_item_t want;

        mode      = 0;
        seg_left  = 0;
        stall_cnt = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got = '{out_bit: out_ch.out_bit, has_bit: out_ch.has_bit,
                        last: out_ch.last, empty_interval: out_ch.empty_interval};
                n_checked++;
                if (got.empty_interval)
                begin
                    n_empty++;
                end
                if (pending_bits.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: result item with nothing pending, got %b", got);
                    end
                end
                else
                begin
                    want = pending_bits.pop_front();
                    if (got.out_bit !== want.out_bit || got.has_bit !== want.has_bit ||
                        got.last !== want.last ||
                        got.empty_interval !== want.empty_interval)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch at %0t: expected bit %b has %b last %b empty %b",
                                     $realtime, want.out_bit, want.has_bit, want.last,
                                     want.empty_interval,
                                     ", got bit %b has %b last %b empty %b",
                                     got.out_bit, got.has_bit, got.last,
                                     got.empty_interval);
                        end
                    end
                end
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_cnt == 0)
                    begin
                        out_ch.ready <= 1'b1;
                        stall_cnt = $urandom_range(5, MAX_STALL);
                    end
                    else
                    begin
                        out_ch.ready <= 1'b0;
                        stall_cnt--;
                    end
                end
            endcase
        end
    end

    task automatic send_item(input code_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= r.action;
        in_ch.symbol      <= r.symbol;
        in_ch.mps_value   <= r.mps_value;
        in_ch.count_mps   <= r.count_mps;
        in_ch.total_count <= r.total_count;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predict_bits(r);
        n_items++;
        if (r.action == ACT_CLOSE)
        begin
            n_closes++;
        end
    endtask

    task automatic send_encode(input logic sym, input logic mps, input int cnt, input int tot);
        send_item('{action: ACT_ENCODE, symbol: sym, mps_value: mps,
                    count_mps: FIELD_W'(cnt), total_count: FIELD_W'(tot)});
    endtask

    task automatic send_close();
        send_item('{action: ACT_CLOSE, symbol: 1'($urandom_range(0, 1)),
                    mps_value: 1'($urandom_range(0, 1)),
                    count_mps: FIELD_W'($urandom), total_count: FIELD_W'($urandom)});
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_bits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_precision(input logic [PREC_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        prec_reg = v;
        restart_interval();
        n_prec_sets++;
    endtask

    function automatic code_req_t random_req();
        code_req_t r;
        int        tot;
        int        sel;
        r.action    = ($urandom_range(0, 15) == 0) ? ACT_CLOSE : ACT_ENCODE;
        r.mps_value = 1'($urandom_range(0, 1));
        r.symbol    = ($urandom_range(0, 9) < 7) ? r.mps_value : ~r.mps_value;
        sel = $urandom_range(0, 24);
        if (sel == 0)
        begin
            tot = 0;
        end
        else if (sel < 6)
        begin
            tot = $urandom_range(1, 16);
        end
        else if (sel < 12)
        begin
            tot = $urandom_range(1, 1023);
        end
        else if (sel == 12)
        begin
            tot = 65535;
        end
        else
        begin
            tot = $urandom_range(1, 65535);
        end
        r.total_count = FIELD_W'(tot);
        if ($urandom_range(0, 9) == 0)
        begin
            r.count_mps = FIELD_W'($urandom);
        end
        else
        begin
            r.count_mps = FIELD_W'($urandom_range(0, tot));
        end
        if (r.action == ACT_CLOSE)
        begin
            r.count_mps   = FIELD_W'($urandom);
            r.total_count = FIELD_W'($urandom);
        end
        return r;
    endfunction

    task automatic test_default_precision();
        send_encode(1'b1, 1'b1, 65535, 65535);
        send_encode(1'b0, 1'b0, 5, 0);
        send_encode(1'b0, 1'b0, 0, 7);
        send_encode(1'b1, 1'b0, 9, 9);
        send_encode(1'b0, 1'b0, 65535, 3);
        send_encode(1'b1, 1'b1, 1, 2);
        send_encode(1'b0, 1'b1, 1, 2);
        send_encode(1'b1, 1'b0, 0, 65535);
        send_close();
        wait_idle();
    endtask

    task automatic test_precision_extremes();
        write_precision(PREC_W'(2));
        send_encode(1'b0, 1'b0, 1, 4);
        send_encode(1'b1, 1'b0, 1, 2);
        send_close();
        wait_idle();
        write_precision(PREC_W'(32));
        send_encode(1'b1, 1'b1, 1, 65535);
        send_encode(1'b0, 1'b1, 65534, 65535);
        send_close();
        wait_idle();
        write_precision(PREC_W'(0));
        send_encode(1'b0, 1'b0, 1, 2);
        send_close();
        wait_idle();
        write_precision({PREC_W{1'b1}});
        send_encode(1'b1, 1'b1, 32767, 65535);
        send_close();
        wait_idle();
        write_precision(PREC_W'(1));
        send_encode(1'b1, 1'b0, 3, 4);
        send_close();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [PREC_W-1:0] prec_list[] = '{12, 2, 32, 8, 24, 5, 16, 31, 40, 3};
        for (int ph = 0; ph < prec_list.size(); ph++)
        begin
            write_precision(prec_list[ph]);
            for (int i = 0; i < 29; i++)
            begin
                if (i == 15)
                begin
                    // hold off until everything is out, then restart the interval
                    wait_idle();
                    write_precision($urandom_range(0, 1) ? prec_list[ph]
                                                         : PREC_W'($urandom_range(0, 63)));
                end
                send_item(random_req());
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_ENCODE;
        in_ch.symbol      <= 1'b0;
        in_ch.mps_value   <= 1'b0;
        in_ch.count_mps   <= '0;
        in_ch.total_count <= '0;
        prec_reg = PREC_W'(RESET_PRECISION);
        restart_interval();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_default_precision();
        test_precision_extremes();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("run covered %0d request items (%0d closes) over %0d precision writes",
                 n_items, n_closes, n_prec_sets);
        $display("%0d result items checked, %0d of them flagged an empty subinterval",
                 n_checked, n_empty);
        if (errors == 0 && pending_bits.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bae_pkg.sv
sv/bae_if.sv
sv/bae_ctrl.sv
sv/bae_dp.sv
sv/binary_arithmetic_encoder.sv
tb/binary_arithmetic_encoder_tb.sv
